// File: design/tbps_pkg.sv
// ============================================================================
// tbps_pkg: shared types and constants of the token bucket packet shaper
// Widths, queue sizing, result kinds, register indexes and controller states.
// ============================================================================
package tbps_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int RATE_W = 20;
    localparam int ELAP_W = 20;
    localparam int LEN_W  = 16;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 2;
    localparam int BKT_W  = 40;
    localparam int NEED_W = 29;

    localparam int UNITS_PER_BYTE = 8000;
    localparam int CAP_PER_KBPS   = 1000000;
    localparam int HALF_PER_KBPS  = 500000;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
    localparam logic [BKT_W-1:0]  BKT_RESET  = BKT_W'(500000000);

    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PASSED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd2;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    localparam logic [1:0] REG_RATE      = 2'd0;
    localparam logic [1:0] REG_ENABLE    = 2'd1;
    localparam logic [1:0] REG_SHAPE_IN  = 2'd2;
    localparam logic [1:0] REG_SHAPE_OUT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REFILL,
        S_CLASS,
        S_RD,
        S_NEED,
        S_CHK,
        S_END
    } t_state;

    typedef struct packed {
        logic [RATE_W-1:0] rate_kbps;
        logic              enable;
        logic              shape_in;
        logic              shape_out;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic              load_in;
        logic              refill;
        logic              set_pend;
        logic [KIND_W-1:0] pend_kind;
        logic              enq;
        logic              rd_head;
        logic              calc_need;
        logic              release_head;
        logic              push_last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cmd;
        logic enable;
        logic shaped;
        logic full;
        logic empty;
        logic fits;
        logic pend_v;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/tbps_dp.sv
// ============================================================================
// tbps_dp: shaper datapath
// Bucket arithmetic, packet queue memory, pending result and output register.
// ============================================================================
module tbps_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbps_pkg::t_cfg                i_cfg,
    input  logic                          i_bkt_load,
    input  logic                          i_cmd,
    input  logic [tbps_pkg::ELAP_W-1:0]   i_elapsed,
    input  logic                          i_outbound,
    input  logic [tbps_pkg::LEN_W-1:0]    i_len,
    input  logic [tbps_pkg::TAG_W-1:0]    i_tag,
    input  tbps_pkg::t_dp_cmd             i_ctl,
    output tbps_pkg::t_dp_stat            o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tbps_pkg::KIND_W-1:0]   o_out_kind,
    output logic [tbps_pkg::TAG_W-1:0]    o_out_tag,
    output logic [tbps_pkg::LEN_W-1:0]    o_out_len,
    output logic                          o_out_last
);

    localparam int BW = tbps_pkg::BKT_W;

    // latched item
    logic                        r_cmd;
    logic                        r_outb;
    logic [tbps_pkg::LEN_W-1:0]  r_len;
    logic [tbps_pkg::TAG_W-1:0]  r_tag;
    logic [BW-1:0]               r_prod;
    logic [BW-1:0]               r_cap;

    logic [BW-1:0]               r_bucket;
    logic [tbps_pkg::NEED_W-1:0] r_need;

    // queue
    logic [tbps_pkg::TAG_W+tbps_pkg::LEN_W-1:0] r_mem [tbps_pkg::QUEUE_DEPTH];
    logic [tbps_pkg::QIDX_W-1:0] r_head;
    logic [tbps_pkg::QCNT_W-1:0] r_count;
    logic [tbps_pkg::TAG_W-1:0]  r_rd_tag;
    logic [tbps_pkg::LEN_W-1:0]  r_rd_len;

    // pending result and output stage
    logic                        r_pend_v;
    logic [tbps_pkg::KIND_W-1:0] r_pend_kind;
    logic [tbps_pkg::TAG_W-1:0]  r_pend_tag;
    logic [tbps_pkg::LEN_W-1:0]  r_pend_len;
    logic                        r_out_v;
    logic [tbps_pkg::KIND_W-1:0] r_out_kind;
    logic [tbps_pkg::TAG_W-1:0]  r_out_tag;
    logic [tbps_pkg::LEN_W-1:0]  r_out_len;
    logic                        r_out_last;

    logic [BW:0]                 w_sum;
    logic [BW-1:0]               w_clip;
    logic [BW-1:0]               w_half;
    logic [tbps_pkg::QCNT_W:0]   w_tail_sum;
    logic [tbps_pkg::QCNT_W:0]   w_tail_wrap;
    logic [tbps_pkg::QIDX_W-1:0] w_tail;
    logic                        w_out_free;
    logic                        w_out_load;

    assign w_sum  = {1'b0, r_bucket} + {1'b0, r_prod};
    assign w_clip = (w_sum > {1'b0, r_cap}) ? r_cap : w_sum[BW-1:0];
    assign w_half = BW'(i_cfg.rate_kbps) * BW'(tbps_pkg::HALF_PER_KBPS);

    assign w_tail_sum  = (tbps_pkg::QCNT_W+1)'(r_head) + (tbps_pkg::QCNT_W+1)'(r_count);
    assign w_tail_wrap = (w_tail_sum >= (tbps_pkg::QCNT_W+1)'(tbps_pkg::QUEUE_DEPTH))
                       ? w_tail_sum - (tbps_pkg::QCNT_W+1)'(tbps_pkg::QUEUE_DEPTH)
                       : w_tail_sum;
    assign w_tail      = w_tail_wrap[tbps_pkg::QIDX_W-1:0];

    assign w_out_free = !r_out_v || i_out_ready;
    assign w_out_load = r_pend_v && (i_ctl.release_head || i_ctl.push_last);

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.enable   = i_cfg.enable;
        o_stat.shaped   = r_outb ? i_cfg.shape_out : i_cfg.shape_in;
        o_stat.full     = (r_count == tbps_pkg::QCNT_W'(tbps_pkg::QUEUE_DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.fits     = (r_bucket >= BW'(r_need));
        o_stat.pend_v   = r_pend_v;
        o_stat.out_free = w_out_free;
    end

    // item capture, the two refill products and the token need
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd  <= i_cmd;
            r_outb <= i_outbound;
            r_len  <= i_len;
            r_tag  <= i_tag;
            r_prod <= BW'(i_cfg.rate_kbps) * BW'(i_elapsed);
            r_cap  <= BW'(i_cfg.rate_kbps) * BW'(tbps_pkg::CAP_PER_KBPS);
        end
        if (i_ctl.calc_need) begin
            r_need <= tbps_pkg::NEED_W'(r_rd_len) *
                      tbps_pkg::NEED_W'(tbps_pkg::UNITS_PER_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket <= tbps_pkg::BKT_RESET;
        end else if (i_bkt_load) begin
            r_bucket <= w_half;
        end else if (i_ctl.refill) begin
            r_bucket <= w_clip;
        end else if (i_ctl.release_head && i_cfg.enable) begin
            r_bucket <= r_bucket - BW'(r_need);
        end
    end

    // queue memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.enq) begin
            r_mem[w_tail] <= {r_tag, r_len};
        end
        if (i_ctl.rd_head) begin
            {r_rd_tag, r_rd_len} <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.enq) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.release_head) begin
            r_head  <= (r_head == tbps_pkg::QIDX_W'(tbps_pkg::QUEUE_DEPTH - 1))
                     ? '0 : r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end
    end

    // pending result: held until it is known whether another result follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_ctl.set_pend || i_ctl.release_head) begin
            r_pend_v <= 1'b1;
        end else if (i_ctl.push_last) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set_pend) begin
            r_pend_kind <= i_ctl.pend_kind;
            r_pend_tag  <= r_tag;
            r_pend_len  <= r_len;
        end else if (i_ctl.release_head) begin
            r_pend_kind <= tbps_pkg::KIND_RELEASED;
            r_pend_tag  <= r_rd_tag;
            r_pend_len  <= r_rd_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= r_pend_kind;
            r_out_tag  <= r_pend_tag;
            r_out_len  <= r_pend_len;
            r_out_last <= i_ctl.push_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_kind  = r_out_kind;
    assign o_out_tag   = r_out_tag;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

endmodule

// File: design/tbps_ctrl.sv
// ============================================================================
// tbps_ctrl: shaper sequencer
// Steps one item through refill, classification and the queue drain loop.
// ============================================================================
module tbps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tbps_pkg::t_dp_stat   i_stat,
    output tbps_pkg::t_dp_cmd    o_ctl
);

    tbps_pkg::t_state r_state;
    tbps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            tbps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = tbps_pkg::S_REFILL;
                end
            end
            tbps_pkg::S_REFILL: begin
                o_ctl.refill = 1'b1;
                n_state      = tbps_pkg::S_CLASS;
            end
            tbps_pkg::S_CLASS: begin
                if (i_stat.cmd == tbps_pkg::CMD_POLL) begin
                    n_state = tbps_pkg::S_RD;
                end else if (!i_stat.enable || !i_stat.shaped) begin
                    o_ctl.set_pend  = 1'b1;
                    o_ctl.pend_kind = tbps_pkg::KIND_PASSED;
                    n_state = i_stat.enable ? tbps_pkg::S_RD : tbps_pkg::S_END;
                end else if (i_stat.full) begin
                    o_ctl.set_pend  = 1'b1;
                    o_ctl.pend_kind = tbps_pkg::KIND_DROPPED;
                    n_state         = tbps_pkg::S_RD;
                end else begin
                    o_ctl.enq = 1'b1;
                    n_state   = tbps_pkg::S_RD;
                end
            end
            tbps_pkg::S_RD: begin
                if (i_stat.empty) begin
                    n_state = tbps_pkg::S_END;
                end else begin
                    o_ctl.rd_head = 1'b1;
                    n_state       = tbps_pkg::S_NEED;
                end
            end
            tbps_pkg::S_NEED: begin
                o_ctl.calc_need = 1'b1;
                n_state         = tbps_pkg::S_CHK;
            end
            tbps_pkg::S_CHK: begin
                if (i_stat.fits || !i_stat.enable) begin
                    if (!i_stat.pend_v || i_stat.out_free) begin
                        o_ctl.release_head = 1'b1;
                        n_state            = tbps_pkg::S_RD;
                    end
                end else begin
                    n_state = tbps_pkg::S_END;
                end
            end
            tbps_pkg::S_END: begin
                if (!i_stat.pend_v) begin
                    n_state = tbps_pkg::S_IDLE;
                end else if (i_stat.out_free) begin
                    o_ctl.push_last = 1'b1;
                    n_state         = tbps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tbps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: design/token_bucket_packet_shaper_core.sv
// ============================================================================
// token_bucket_packet_shaper_core: token bucket shaper with packet queue
// Refills a bucket in 1/8000-byte units, queues shaped packets and releases
// the queue head while it fits the bucket or when disabled; APB-style config.
// ============================================================================
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  --------------------------------
//  s_axis    in   s_axis_tvalid/tready      tdata: elapsed_us, outbound,
//                                           pkt_length, pkt_tag; tuser: cmd
//  m_axis    out  m_axis_tvalid/tready      tdata: out_tag, out_length;
//                                           tuser: kind; tlast: last
//  apb       in   psel & penable & pwrite   paddr 4*index, pwdata, prdata
//
//  Steps: accept, refill, classify and a closing cycle; the drain reads each
//  head, works out its token need and compares, released or not; a read that
//  finds the queue dry ends it; a packet while disabled skips the drain.
//  Reset: synchronous active-low; queue empty, bucket at 500000000 units,
//  rate 1000, disabled, both directions shaped.
//  Stalls: a result waits in a pending stage until its last flag is known;
//  the drain loop and the closing cycle hold while the output register is busy.
//
module token_bucket_packet_shaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [19:0] elapsed_us, [20] outbound,
                                        // [36:21] pkt_length, [52:37] pkt_tag,
                                        // [55:53] zero
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_tag, [31:16] out_length
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tbps_pkg::t_cfg     r_cfg;
    tbps_pkg::t_dp_cmd  w_ctl;
    tbps_pkg::t_dp_stat w_stat;

    logic       w_wr;
    logic [1:0] w_idx;
    logic       w_bkt_load;

    logic [tbps_pkg::KIND_W-1:0] w_kind;
    logic [tbps_pkg::TAG_W-1:0]  w_tag;
    logic [tbps_pkg::LEN_W-1:0]  w_len;

    // register index from the word address
    assign w_idx      = paddr[3:2];
    assign w_wr       = psel && penable && pwrite;
    assign pready     = 1'b1;
    // writing 1 to the enable register reloads the bucket to half capacity
    assign w_bkt_load = w_wr && (w_idx == tbps_pkg::REG_ENABLE) && pwdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_kbps <= tbps_pkg::RATE_RESET;
            r_cfg.enable    <= 1'b0;
            r_cfg.shape_in  <= 1'b1;
            r_cfg.shape_out <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                tbps_pkg::REG_RATE:      r_cfg.rate_kbps <= pwdata[tbps_pkg::RATE_W-1:0];
                tbps_pkg::REG_ENABLE:    r_cfg.enable    <= pwdata[0];
                tbps_pkg::REG_SHAPE_IN:  r_cfg.shape_in  <= pwdata[0];
                tbps_pkg::REG_SHAPE_OUT: r_cfg.shape_out <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            tbps_pkg::REG_RATE:      prdata = 32'(r_cfg.rate_kbps);
            tbps_pkg::REG_ENABLE:    prdata = 32'(r_cfg.enable);
            tbps_pkg::REG_SHAPE_IN:  prdata = 32'(r_cfg.shape_in);
            tbps_pkg::REG_SHAPE_OUT: prdata = 32'(r_cfg.shape_out);
            default:                 prdata = '0;
        endcase
    end

    tbps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    tbps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_bkt_load  (w_bkt_load),
        .i_cmd       (s_axis_tuser[0]),
        .i_elapsed   (s_axis_tdata[19:0]),
        .i_outbound  (s_axis_tdata[20]),
        .i_len       (s_axis_tdata[36:21]),
        .i_tag       (s_axis_tdata[52:37]),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (w_kind),
        .o_out_tag   (w_tag),
        .o_out_len   (w_len),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_len, w_tag};
    assign m_axis_tuser = w_kind;

endmodule
